// ===== hdl/battery_charge_estimator_unit_defines.svh =====
// Assertion macros shared by the battery charge estimator RTL.
`ifndef BATTERY_CHARGE_ESTIMATOR_UNIT_DEFINES_SVH
`define BATTERY_CHARGE_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/bce_pkg.sv =====
// Types, constants and curve tables of the battery charge estimator.
`timescale 1ns / 1ps

package bce_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned MV_W      = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned RATIO_W   = 4;
  localparam int unsigned SCALE_W   = 12;   // width of the full-scale constant
  localparam int unsigned CURVE_W   = 13;   // width of a curve breakpoint
  localparam int unsigned SEG_IDX_W = 4;
  localparam int unsigned CURVE_POINTS = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [SCALE_W-1:0]   FULL_SCALE_MV  = 12'd2450;
  localparam logic [RATIO_W-1:0]   RATIO_RESET    = 4'd2;
  localparam logic [PCT_W-1:0]     PCT_FULL       = 7'd100;
  localparam logic [PCT_W-1:0]     PCT_EMPTY      = 7'd0;
  localparam logic [3:0]           PCT_STEP       = 4'd10;
  localparam logic [CURVE_W-1:0]   MV_TOP         = 13'd4200;
  localparam logic [CURVE_W-1:0]   MV_BOTTOM      = 13'd3300;

  // register index, taken from paddr[2]
  localparam logic REG_DIVIDER_RATIO = 1'b0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                sample_ok;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0]  battery_millivolts;
    logic [PCT_W-1:0] charge_percent;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_SCALE,
    ST_MV_DIV,
    ST_RATIO,
    ST_SEG,
    ST_PCT_DIV,
    ST_PCT,
    ST_OUT
  } state_t;

  function automatic logic [CURVE_W-1:0] curve_mv(input logic [SEG_IDX_W-1:0] k);
    logic [CURVE_W-1:0] r;
    case (k)
      4'd0:    r = 13'd4200;
      4'd1:    r = 13'd4050;
      4'd2:    r = 13'd3950;
      4'd3:    r = 13'd3850;
      4'd4:    r = 13'd3780;
      4'd5:    r = 13'd3730;
      4'd6:    r = 13'd3690;
      4'd7:    r = 13'd3650;
      4'd8:    r = 13'd3600;
      4'd9:    r = 13'd3500;
      4'd10:   r = 13'd3300;
      default: r = 13'd3300;
    endcase
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_IDX_W-1:0] k);
    logic [PCT_W-1:0] r;
    case (k)
      4'd0:    r = 7'd100;
      4'd1:    r = 7'd90;
      4'd2:    r = 7'd80;
      4'd3:    r = 7'd70;
      4'd4:    r = 7'd60;
      4'd5:    r = 7'd50;
      4'd6:    r = 7'd40;
      4'd7:    r = 7'd30;
      4'd8:    r = 7'd20;
      4'd9:    r = 7'd10;
      4'd10:   r = 7'd0;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/battery_charge_estimator_unit.sv =====
// Battery charge estimator: sample averaging, scaling and discharge-curve lookup.
//
//  port group   dir  flow control     payload
//  in_*         in   valid / stall    bce_pkg::in_item_t  (sample_value, sample_ok)
//  out_*        out  valid / stall    bce_pkg::out_item_t (battery_millivolts, charge_percent)
//  APB          in   pready tied high divider_ratio at byte address 0
//
// A sample that does not close a window is taken without stalling the input.
// The sample that closes a window stalls the input for six sequencing steps (average,
// scale, reciprocal divide, ratio, segment, output load); inside the curve the percent
// interpolation adds a restoring division of the ADC_BITS+12-bit dividend on the shared
// shift/subtract unit, followed by the percent add.
// Reset sets divider_ratio to 2 and clears the sum, count and output valid.
// A stalled result holds in the output register; the unit keeps accepting
// samples and only waits for the slot when it has a new result to load.
`timescale 1ns / 1ps
`include "battery_charge_estimator_unit_defines.svh"

module battery_charge_estimator_unit #(
  parameter int unsigned SAMPLES_PER_RESULT = 16,
  parameter int unsigned ADC_BITS           = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bce_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bce_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bce_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [bce_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [bce_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_RESULT);
  localparam int unsigned SUM_W = ADC_BITS + $clog2(SAMPLES_PER_RESULT);
  localparam int unsigned DW    = ADC_BITS + bce_pkg::SCALE_W;  // dividend width
  localparam int unsigned DVW   = ADC_BITS;                     // divisor width
  localparam int unsigned DC_W  = $clog2(DW);
  localparam int unsigned DIFF_W = 8;                           // widest segment is 200 mV

  // constant divisions done as multiply by a rounded-up reciprocal, exact for
  // every dividend of the given width
  localparam int unsigned AVG_SH = SUM_W + $clog2(SAMPLES_PER_RESULT);
  localparam int unsigned MV_SH  = DW + ADC_BITS;
  localparam int unsigned AP_W   = 2 * SUM_W + 1;
  localparam int unsigned MP_W   = 2 * DW + 1;
  localparam longint unsigned ADC_FULL = (64'd1 << ADC_BITS) - 64'd1;
  localparam longint unsigned AVG_RCP  =
    ((64'd1 << AVG_SH) + 64'(SAMPLES_PER_RESULT) - 64'd1) / 64'(SAMPLES_PER_RESULT);
  localparam longint unsigned MV_RCP   = ((64'd1 << MV_SH) + ADC_FULL - 64'd1) / ADC_FULL;

  bce_pkg::state_t state_r, state_nxt;

  logic [bce_pkg::RATIO_W-1:0] ratio_r;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;

  logic [DW-1:0]   div_quo_r, div_quo_nxt;
  logic [DVW-1:0]  div_rem_r, div_rem_nxt;
  logic [DVW-1:0]  div_dvs_r, div_dvs_nxt;
  logic [DC_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [bce_pkg::MV_W-1:0]  mv_r, mv_nxt;
  logic [bce_pkg::PCT_W-1:0] pct_r, pct_nxt;
  logic [bce_pkg::PCT_W-1:0] base_r, base_nxt;

  logic                      out_valid_r, out_valid_nxt;
  bce_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                      in_take;
  logic                      last_sample;
  logic                      div_last;
  logic                      out_free;
  logic [ADC_BITS-1:0]       sample;
  logic [SUM_W-1:0]          sum_add;
  logic [DVW:0]              rem_sh;
  logic                      rem_ge;
  logic [DW-1:0]             quo_sh;
  logic [AP_W-1:0]           avg_prod;
  logic [MP_W-1:0]           mv_prod;
  logic [bce_pkg::SEG_IDX_W-1:0] seg;
  logic [bce_pkg::CURVE_W-1:0]   seg_hi, seg_lo;
  logic [DIFF_W-1:0]         seg_off;
  logic [DIFF_W-1:0]         seg_span;
  logic                      at_top, at_bottom;
  logic                      cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == bce_pkg::REG_DIVIDER_RATIO) begin
      prdata = bce_pkg::APB_DATA_W'(ratio_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= bce_pkg::RATIO_RESET;
    end else if (cfg_wr && paddr[2] == bce_pkg::REG_DIVIDER_RATIO) begin
      ratio_r <= pwdata[bce_pkg::RATIO_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign in_stall    = (state_r != bce_pkg::ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign last_sample = (cnt_r == CNT_W'(SAMPLES_PER_RESULT - 1));
  assign out_free    = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign sample  = in_data.sample_ok ? ADC_BITS'(in_data.sample_value) : '0;
  assign sum_add = SUM_W'(sum_r + SUM_W'(sample));

  // ---------------- constant divisions ----------------
  assign avg_prod = AP_W'(div_quo_r[SUM_W-1:0]) * AP_W'(AVG_RCP);
  assign mv_prod  = MP_W'(div_quo_r) * MP_W'(MV_RCP);

  // ---------------- shared divider step ----------------
  assign rem_sh   = {div_rem_r, div_quo_r[DW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_dvs_r});
  assign quo_sh   = {div_quo_r[DW-2:0], rem_ge};
  assign div_last = (div_cnt_r == DC_W'(DW - 1));

  // ---------------- segment search ----------------
  always_comb begin
    logic found;
    found = 1'b0;
    seg   = '0;
    for (int k = 0; k < bce_pkg::CURVE_POINTS - 1; k++) begin
      if (!found
          && mv_r <= bce_pkg::MV_W'(bce_pkg::curve_mv(bce_pkg::SEG_IDX_W'(k)))
          && mv_r >= bce_pkg::MV_W'(bce_pkg::curve_mv(bce_pkg::SEG_IDX_W'(k + 1)))) begin
        found = 1'b1;
        seg   = bce_pkg::SEG_IDX_W'(k);
      end
    end
  end

  assign seg_hi    = bce_pkg::curve_mv(seg);
  assign seg_lo    = bce_pkg::curve_mv(bce_pkg::SEG_IDX_W'(seg + 1'b1));
  assign seg_off   = DIFF_W'(mv_r - bce_pkg::MV_W'(seg_lo));
  assign seg_span  = DIFF_W'(seg_hi - seg_lo);
  assign at_top    = (mv_r >= bce_pkg::MV_W'(bce_pkg::MV_TOP));
  assign at_bottom = (mv_r <= bce_pkg::MV_W'(bce_pkg::MV_BOTTOM));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bce_pkg::ST_IDLE: begin
        if (in_take && last_sample) state_nxt = bce_pkg::ST_AVG_DIV;
      end
      bce_pkg::ST_AVG_DIV: state_nxt = bce_pkg::ST_SCALE;
      bce_pkg::ST_SCALE:   state_nxt = bce_pkg::ST_MV_DIV;
      bce_pkg::ST_MV_DIV:  state_nxt = bce_pkg::ST_RATIO;
      bce_pkg::ST_RATIO:   state_nxt = bce_pkg::ST_SEG;
      bce_pkg::ST_SEG: begin
        if (at_top || at_bottom) state_nxt = bce_pkg::ST_OUT;
        else                     state_nxt = bce_pkg::ST_PCT_DIV;
      end
      bce_pkg::ST_PCT_DIV: begin
        if (div_last) state_nxt = bce_pkg::ST_PCT;
      end
      bce_pkg::ST_PCT:     state_nxt = bce_pkg::ST_OUT;
      bce_pkg::ST_OUT: begin
        if (out_free) state_nxt = bce_pkg::ST_IDLE;
      end
      default:             state_nxt = bce_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    div_quo_nxt   = div_quo_r;
    div_rem_nxt   = div_rem_r;
    div_dvs_nxt   = div_dvs_r;
    div_cnt_nxt   = div_cnt_r;
    mv_nxt        = mv_r;
    pct_nxt       = pct_r;
    base_nxt      = base_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      bce_pkg::ST_IDLE: begin
        if (in_take) begin
          if (last_sample) begin
            sum_nxt     = '0;
            cnt_nxt     = '0;
            div_quo_nxt = DW'(sum_add);
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = CNT_W'(cnt_r + 1'b1);
          end
        end
      end
      bce_pkg::ST_AVG_DIV: begin
        div_quo_nxt = DW'(avg_prod[AVG_SH +: ADC_BITS]);
      end
      bce_pkg::ST_SCALE: begin
        // average fits ADC_BITS; scale by full-scale millivolts over the code range
        div_quo_nxt = DW'(DW'(div_quo_r[ADC_BITS-1:0]) * DW'(bce_pkg::FULL_SCALE_MV));
      end
      bce_pkg::ST_MV_DIV: begin
        div_quo_nxt = DW'(mv_prod[MV_SH +: bce_pkg::SCALE_W]);
      end
      bce_pkg::ST_PCT_DIV: begin
        div_quo_nxt = quo_sh;
        div_rem_nxt = rem_ge ? DVW'(rem_sh - {1'b0, div_dvs_r}) : rem_sh[DVW-1:0];
        div_cnt_nxt = DC_W'(div_cnt_r + 1'b1);
      end
      bce_pkg::ST_RATIO: begin
        mv_nxt = bce_pkg::MV_W'(bce_pkg::MV_W'(div_quo_r[bce_pkg::SCALE_W-1:0])
                                * bce_pkg::MV_W'(ratio_r));
      end
      bce_pkg::ST_SEG: begin
        if (at_top) begin
          pct_nxt = bce_pkg::PCT_FULL;
        end else if (at_bottom) begin
          pct_nxt = bce_pkg::PCT_EMPTY;
        end else begin
          base_nxt    = bce_pkg::curve_pct(bce_pkg::SEG_IDX_W'(seg + 1'b1));
          div_quo_nxt = DW'(DW'(seg_off) * DW'(bce_pkg::PCT_STEP));
          div_rem_nxt = '0;
          div_dvs_nxt = DVW'(seg_span);
          div_cnt_nxt = '0;
        end
      end
      bce_pkg::ST_PCT: begin
        pct_nxt = bce_pkg::PCT_W'(base_r + div_quo_r[bce_pkg::PCT_W-1:0]);
      end
      bce_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.battery_millivolts = mv_r;
          out_data_nxt.charge_percent     = pct_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bce_pkg::ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_quo_r  <= div_quo_nxt;
    div_rem_r  <= div_rem_nxt;
    div_dvs_r  <= div_dvs_nxt;
    div_cnt_r  <= div_cnt_nxt;
    mv_r       <= mv_nxt;
    pct_r      <= pct_nxt;
    base_r     <= base_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------- assertions ----------------
  `BCE_ASSERT_NEXT(a_out_load, clk, rst_n,
    state_r == bce_pkg::ST_OUT && out_free,
    out_valid_r && state_r == bce_pkg::ST_IDLE)

  `BCE_ASSERT_NOW(a_full_iff_top, clk, rst_n,
    out_valid_r,
    (out_data_r.charge_percent == bce_pkg::PCT_FULL)
      == (out_data_r.battery_millivolts >= bce_pkg::MV_W'(bce_pkg::MV_TOP)))

  `BCE_ASSERT_NOW(a_interp_in_segment, clk, rst_n,
    state_r == bce_pkg::ST_PCT,
    div_quo_r < DW'(bce_pkg::PCT_STEP))

endmodule
